[rtl/csvqs_pkg.sv]
// Shared types, constants and helpers of the CSV quote-aware delimiter scanner.
package csvqs_pkg;

   localparam int LANES      = 8;
   localparam int BYTE_W     = 8;
   localparam int LANE_W     = 3;
   localparam int VB_W       = 4;
   localparam int PCNT_W     = $clog2(LANES + 1);
   localparam int LEN_W      = 24;
   localparam int CNT_W      = 40;

   localparam logic [BYTE_W-1:0] QUOTE_BYTE   = 8'h22;
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [BYTE_W-1:0] DELIM_RESET  = 8'h2C;
   localparam logic [LEN_W-1:0]  LEN_MAX      = {LEN_W{1'b1}};

   localparam int REQ_FIELD_W = LANES * BYTE_W + VB_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = LANE_W + LEN_W + 2 * CNT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DELIMITER = 1'b1;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   typedef struct packed {
      logic is_quote;
      logic is_newline;
      logic is_delim;
   } lane_class_type;

   typedef struct packed {
      logic                              cell_mode;
      logic [LANES-1:0]                  mask;
      logic [LANES-1:0]                  kind;
      logic [LANES-1:0][LEN_W-1:0]       lens;
      logic [LANES-1:0][PCNT_W-1:0]      cell_pre;
      logic [LANES-1:0][PCNT_W-1:0]      row_pre;
      logic [CNT_W-1:0]                  cell_base;
      logic [CNT_W-1:0]                  row_base;
   } event_rec_type;

   // Saturating add of a short distance onto a field length.
   function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0]  base,
                                               input logic [PCNT_W-1:0] step);
      logic [LEN_W:0] sum;
      sum = {1'b0, base} + {{(LEN_W + 1 - PCNT_W){1'b0}}, step};
      return sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
   endfunction

endpackage

[rtl/csvqs_lane.sv]
// One byte lane: classify the byte as quote, newline or delimiter.
module csvqs_lane (
   input  logic [csvqs_pkg::BYTE_W-1:0] lane_byte,
   input  logic                         lane_on,
   input  logic                         cell_mode,
   input  logic [csvqs_pkg::BYTE_W-1:0] delimiter,
   output csvqs_pkg::lane_class_type    lane_class
);

   always_comb begin
      lane_class.is_quote   = lane_on && (lane_byte == csvqs_pkg::QUOTE_BYTE);
      lane_class.is_newline = lane_on && (lane_byte == csvqs_pkg::NEWLINE_BYTE);
      lane_class.is_delim   = lane_on && cell_mode && (lane_byte == delimiter);
   end

endmodule

[rtl/csvqs_merge.sv]
// Merge stage: quote prefix XOR, field lengths, running counts and scanner state.
module csvqs_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  logic                                        restart,
   input  logic [csvqs_pkg::PCNT_W-1:0]                vcnt,
   input  logic                                        cell_mode,
   input  csvqs_pkg::lane_class_type [csvqs_pkg::LANES-1:0] lane_class,
   output csvqs_pkg::event_rec_type                    rec,
   output logic                                        has_event
);

   logic                            in_quotes_ff, in_quotes_in;
   logic [csvqs_pkg::LEN_W-1:0]     run_len_ff, run_len_in;
   logic [csvqs_pkg::CNT_W-1:0]     cells_ff, cells_in;
   logic [csvqs_pkg::CNT_W-1:0]     rows_ff, rows_in;

   always_comb begin
      logic                          q;
      logic                          have;
      logic [csvqs_pkg::PCNT_W-1:0]  start;
      logic [csvqs_pkg::PCNT_W-1:0]  gap;
      logic [csvqs_pkg::PCNT_W-1:0]  cc;
      logic [csvqs_pkg::PCNT_W-1:0]  rc;
      logic [csvqs_pkg::LEN_W-1:0]   base;
      logic                          strct;
      q     = in_quotes_ff;
      have  = 1'b0;
      start = '0;
      cc    = '0;
      rc    = '0;
      base  = restart ? '0 : run_len_ff;
      rec.cell_mode = cell_mode;
      rec.cell_base = cells_ff;
      rec.row_base  = rows_ff;
      for (int k = 0; k < csvqs_pkg::LANES; k++) begin
         // quote state seen by this lane comes from all earlier lanes
         strct = !lane_class[k].is_quote && !q &&
                 (lane_class[k].is_newline || lane_class[k].is_delim);
         gap   = csvqs_pkg::PCNT_W'(k) - start;
         rec.mask[k] = strct;
         rec.kind[k] = lane_class[k].is_newline ? csvqs_pkg::KIND_ROW
                                                : csvqs_pkg::KIND_CELL;
         rec.lens[k] = have ? csvqs_pkg::LEN_W'(gap) : csvqs_pkg::sat_add(base, gap);
         if (strct) begin
            cc = cc + 1'b1;
            if (lane_class[k].is_newline) begin
               rc = rc + 1'b1;
            end
            have  = 1'b1;
            start = csvqs_pkg::PCNT_W'(k) + 1'b1;
         end
         rec.cell_pre[k] = cc;
         rec.row_pre[k]  = rc;
         q = q ^ lane_class[k].is_quote;
      end
      gap          = vcnt - start;
      in_quotes_in = q;
      run_len_in   = have ? csvqs_pkg::LEN_W'(gap) : csvqs_pkg::sat_add(base, gap);
      cells_in     = cells_ff + (cell_mode ? csvqs_pkg::CNT_W'(cc) : '0);
      rows_in      = rows_ff + csvqs_pkg::CNT_W'(rc);
      has_event    = have;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0;
         run_len_ff   <= '0;
         cells_ff     <= '0;
         rows_ff      <= '0;
      end else if (accept) begin
         in_quotes_ff <= in_quotes_in;
         run_len_ff   <= run_len_in;
         cells_ff     <= cells_in;
         rows_ff      <= rows_in;
      end
   end

endmodule

[rtl/csvqs_evq.sv]
// Event queue: hold per-beat event records, send one event per cycle unless stalled.
module csvqs_evq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  csvqs_pkg::event_rec_type             push_rec,
   output logic                                 room,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 out_kind,
   output logic [csvqs_pkg::LANE_W-1:0]         out_lane,
   output logic [csvqs_pkg::LEN_W-1:0]          out_len,
   output logic [csvqs_pkg::CNT_W-1:0]          out_cells,
   output logic [csvqs_pkg::CNT_W-1:0]          out_rows,
   output logic                                 out_last
);

   csvqs_pkg::event_rec_type          recs_ff [csvqs_pkg::QDEPTH];
   logic [csvqs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [csvqs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [csvqs_pkg::QPTR_W:0]        count_ff, count_in;
   logic [csvqs_pkg::LANES-1:0]       done_ff, done_in;
   logic                              valid_ff, valid_in;

   csvqs_pkg::event_rec_type          head;
   logic [csvqs_pkg::LANES-1:0]       remain;
   logic [csvqs_pkg::LANES-1:0]       pick;
   logic [csvqs_pkg::LANE_W-1:0]      sel;
   logic                              is_last;
   logic                              load;
   logic                              pop;

   always_comb begin
      head   = recs_ff[rd_ptr_ff];
      remain = head.mask & ~done_ff;
      pick   = remain & (~remain + 1'b1);
      sel    = '0;
      for (int k = csvqs_pkg::LANES - 1; k >= 0; k--) begin
         if (remain[k]) begin
            sel = csvqs_pkg::LANE_W'(k);
         end
      end
      is_last = (remain & ~pick) == '0;
      load    = (count_ff != '0) && (!valid_ff || rsp_tready);
      pop     = load && is_last;

      room      = count_ff != (csvqs_pkg::QPTR_W + 1)'(csvqs_pkg::QDEPTH);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{csvqs_pkg::QPTR_W{1'b0}}, push}
                           - {{csvqs_pkg::QPTR_W{1'b0}}, pop};
      done_in   = pop ? '0 : (load ? (done_ff | pick) : done_ff);
      valid_in  = load || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         done_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         done_ff   <= done_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         recs_ff[wr_ptr_ff] <= push_rec;
      end
      if (load) begin
         out_kind  <= head.kind[sel];
         out_lane  <= sel;
         out_len   <= head.lens[sel];
         out_cells <= head.cell_mode
                      ? head.cell_base + csvqs_pkg::CNT_W'(head.cell_pre[sel]) : '0;
         out_rows  <= head.row_base + csvqs_pkg::CNT_W'(head.row_pre[sel]);
         out_last  <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

[rtl/csv_quote_aware_delimiter_scanner.sv]
// Top level of the CSV quote-aware delimiter scanner: lanes, merge, event queue, registers.
//
// The scanner takes CSV text eight bytes per beat (lane 0 first) and reports every
// structural byte that lies outside double quotes: a newline ends a row (and a cell
// in cell mode), the configured delimiter ends a cell in cell mode. Each quote toggles
// the carried inside-quotes flag; eight lane classifiers feed a merge stage that runs
// the quote prefix XOR, the field lengths (saturating at 2^24-1) and the 40-bit cell
// and row counts, which wrap. A beat with restart set clears the field length before
// its first lane but keeps the quote flag. Each beat that finds structural bytes
// stores one record in a four-entry queue; the output register then delivers that
// record's events one per cycle while rsp_tready holds, lowest lane first, with tlast
// on the beat's final event. Beats without structural bytes produce nothing. Input beats
// are taken one per cycle while the queue has room; a beat carries up to 8 events, which
// leave one at a time through the single event output port. The first event of a beat
// passes through its queue entry and then the output register before rsp_tvalid shows it.
// Registers: cell_mode at byte address 0 (reset 0), delimiter_byte at 4 (reset 0x2C);
// write them only while the scanner is idle.
module csv_quote_aware_delimiter_scanner (
   input  logic                                 clock,
   input  logic                                 reset,
   // request beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [csvqs_pkg::REQ_TDATA_W-1:0]    req_tdata,  // byte_lanes[63:0], valid_bytes[67:64]
   input  logic                                 req_tuser,  // restart
   // event beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [csvqs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // lane_index[2:0], field_length[26:3],
                                                            // cell_total[66:27], row_total[106:67]
   output logic                                 rsp_tuser,  // event_kind
   output logic                                 rsp_tlast,  // last_event
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [csvqs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [csvqs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [csvqs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   logic                                    cell_mode_ff, cell_mode_in;
   logic [csvqs_pkg::BYTE_W-1:0]            delim_ff, delim_in;
   logic [csvqs_pkg::CSR_IDX_W-1:0]         csr_idx;
   logic                                    csr_wr;

   logic [csvqs_pkg::VB_W-1:0]              valid_bytes;
   logic [csvqs_pkg::PCNT_W-1:0]            vcnt;
   csvqs_pkg::lane_class_type [csvqs_pkg::LANES-1:0] lane_class;
   csvqs_pkg::event_rec_type                rec;
   logic                                    has_event;
   logic                                    room;
   logic                                    accept;

   logic                                    out_kind;
   logic [csvqs_pkg::LANE_W-1:0]            out_lane;
   logic [csvqs_pkg::LEN_W-1:0]             out_len;
   logic [csvqs_pkg::CNT_W-1:0]             out_cells;
   logic [csvqs_pkg::CNT_W-1:0]             out_rows;
   logic                                    out_last;

   // register port: write on the access phase, pready tied high
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[csvqs_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cell_mode_in = cell_mode_ff;
      delim_in     = delim_ff;
      csr_prdata   = '0;
      case (csr_idx)
         csvqs_pkg::REG_CELL_MODE: begin
            csr_prdata = {{(csvqs_pkg::CSR_DATA_W - 1){1'b0}}, cell_mode_ff};
            if (csr_wr) begin
               cell_mode_in = csr_pwdata[0];
            end
         end
         csvqs_pkg::REG_DELIMITER: begin
            csr_prdata = {{(csvqs_pkg::CSR_DATA_W - csvqs_pkg::BYTE_W){1'b0}}, delim_ff};
            if (csr_wr) begin
               delim_in = csr_pwdata[csvqs_pkg::BYTE_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_mode_ff <= 1'b0;
         delim_ff     <= csvqs_pkg::DELIM_RESET;
      end else begin
         cell_mode_ff <= cell_mode_in;
         delim_ff     <= delim_in;
      end
   end

   // take a beat whenever the queue can hold its record
   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   // clamp the valid count to the lane count
   assign valid_bytes = req_tdata[csvqs_pkg::LANES*csvqs_pkg::BYTE_W +: csvqs_pkg::VB_W];
   assign vcnt = (valid_bytes > csvqs_pkg::VB_W'(csvqs_pkg::LANES))
                 ? csvqs_pkg::PCNT_W'(csvqs_pkg::LANES)
                 : csvqs_pkg::PCNT_W'(valid_bytes);

   for (genvar g = 0; g < csvqs_pkg::LANES; g++) begin : g_lane
      csvqs_lane u_lane (
         .lane_byte  (req_tdata[g*csvqs_pkg::BYTE_W +: csvqs_pkg::BYTE_W]),
         .lane_on    (csvqs_pkg::PCNT_W'(g) < vcnt),
         .cell_mode  (cell_mode_ff),
         .delimiter  (delim_ff),
         .lane_class (lane_class[g])
      );
   end

   csvqs_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .restart    (req_tuser),
      .vcnt       (vcnt),
      .cell_mode  (cell_mode_ff),
      .lane_class (lane_class),
      .rec        (rec),
      .has_event  (has_event)
   );

   // drop beats with no structural byte; queue the rest
   csvqs_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && has_event),
      .push_rec   (rec),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_kind   (out_kind),
      .out_lane   (out_lane),
      .out_len    (out_len),
      .out_cells  (out_cells),
      .out_rows   (out_rows),
      .out_last   (out_last)
   );

   assign rsp_tdata = {{(csvqs_pkg::RSP_TDATA_W - csvqs_pkg::RSP_FIELD_W){1'b0}},
                       out_rows, out_cells, out_len, out_lane};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

[dv/tb_top.sv]
// Testbench for the CSV quote-aware delimiter scanner: stream stimulus, event scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
   logic                          kind;
   logic [csvqs_pkg::LANE_W-1:0]  lane;
   logic [csvqs_pkg::LEN_W-1:0]   len;
   logic [csvqs_pkg::CNT_W-1:0]   cells;
   logic [csvqs_pkg::CNT_W-1:0]   rows;
   logic                          last;
} scan_event_type;

// Track the scanner state for every accepted beat and hold the events it must emit.
class event_scoreboard;
   logic                          cell_mode = 1'b0;
   logic [7:0]                    delim     = csvqs_pkg::DELIM_RESET;
   logic                          quoted    = 1'b0;
   logic [csvqs_pkg::LEN_W-1:0]   run_len   = '0;
   logic [csvqs_pkg::CNT_W-1:0]   cells     = '0;
   logic [csvqs_pkg::CNT_W-1:0]   rows      = '0;
   scan_event_type                expected[$];
   int unsigned                   errors    = 0;
   int unsigned                   checked   = 0;

   function void set_reg(logic [csvqs_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == csvqs_pkg::REG_CELL_MODE)
         cell_mode = val[0];
      else if (idx == csvqs_pkg::REG_DELIMITER)
         delim = val[7:0];
   endfunction

   function int pending();
      return expected.size();
   endfunction

   // Walk the lanes of one accepted beat and queue the events it causes.
   function void note_beat(logic [63:0] lanes, logic [3:0] vb, logic rs);
      scan_event_type ev;
      logic        held;
      logic        hit;
      logic        kind;
      logic [7:0]  b;
      int          span;
      held = 1'b0;
      ev   = '0;
      span = (vb > csvqs_pkg::LANES) ? csvqs_pkg::LANES : int'(vb);
      if (rs)
         run_len = '0;
      for (int k = 0; k < span; k++) begin
         b    = lanes[8*k +: 8];
         hit  = 1'b0;
         kind = csvqs_pkg::KIND_CELL;
         if (b == csvqs_pkg::QUOTE_BYTE) begin
            quoted = !quoted;
         end else if (!quoted) begin
            if (b == csvqs_pkg::NEWLINE_BYTE) begin
               hit  = 1'b1;
               kind = csvqs_pkg::KIND_ROW;
            end else if (cell_mode && b == delim) begin
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (run_len != csvqs_pkg::LEN_MAX)
               run_len = run_len + 1'b1;
         end else begin
            if (held)
               expected.push_back(ev);
            if (cell_mode)
               cells = cells + 1'b1;
            if (kind == csvqs_pkg::KIND_ROW)
               rows = rows + 1'b1;
            ev.kind  = kind;
            ev.lane  = 3'(k);
            ev.len   = run_len;
            ev.cells = cell_mode ? cells : '0;
            ev.rows  = rows;
            ev.last  = 1'b0;
            held     = 1'b1;
            run_len  = '0;
         end
      end
      if (held) begin
         ev.last = 1'b1;
         expected.push_back(ev);
      end
   endfunction

   function void flag(string what, scan_event_type want, scan_event_type got);
      errors++;
      if (errors <= 10) begin
         $display("[%0t] %s", $realtime, what);
         $display("   expected kind=%0d lane=%0d len=%0d cells=%0d rows=%0d last=%0d",
                  want.kind, want.lane, want.len, want.cells, want.rows, want.last);
         $display("   actual   kind=%0d lane=%0d len=%0d cells=%0d rows=%0d last=%0d",
                  got.kind, got.lane, got.len, got.cells, got.rows, got.last);
      end
   endfunction

   function void check_event(scan_event_type got);
      scan_event_type want;
      checked++;
      if (expected.size() == 0) begin
         flag("event arrived with nothing expected", '0, got);
      end else begin
         want = expected.pop_front();
         if (want !== got)
            flag("event mismatch", want, got);
      end
   endfunction
endclass

module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 12;
   localparam int PHASES      = 8;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_tvalid  = 1'b0;
   logic                                req_tready;
   logic [csvqs_pkg::REQ_TDATA_W-1:0]   req_tdata   = '0;
   logic                                req_tuser   = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready  = 1'b0;
   logic [csvqs_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [csvqs_pkg::CSR_ADDR_W-1:0]    csr_paddr   = '0;
   logic [csvqs_pkg::CSR_DATA_W-1:0]    csr_pwdata  = '0;
   logic [csvqs_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   event_scoreboard sb = new();

   int unsigned cycles     = 0;
   int unsigned beats_sent = 0;
   int unsigned settings   = 1;
   logic        steady     = 1'b0;   // high: neither side idles

   // Random-phase register settings: row mode, default comma, tab, quote as delimiter,
   // newline as delimiter, the two byte extremes, then row mode with a stale delimiter.
   logic       phase_mode  [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
   logic [7:0] phase_delim [PHASES] = '{8'h2C, 8'h2C, 8'h09, 8'h22, 8'h0A, 8'h00, 8'hFF, 8'h3B};

   csv_quote_aware_delimiter_scanner uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count cycles and kill a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d events outstanding", cycles, sb.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Event side: stall about 15% of cycles unless in the steady stretch; check each
   // accepted event against the oldest expectation. Values read here are pre-edge.
   always @(posedge clock) begin
      scan_event_type got;
      rsp_tready <= steady || ($urandom_range(99) >= 15);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind  = rsp_tuser;
         got.lane  = rsp_tdata[csvqs_pkg::LANE_W-1:0];
         got.len   = rsp_tdata[csvqs_pkg::LANE_W +: csvqs_pkg::LEN_W];
         got.cells = rsp_tdata[csvqs_pkg::LANE_W + csvqs_pkg::LEN_W +: csvqs_pkg::CNT_W];
         got.rows  = rsp_tdata[csvqs_pkg::LANE_W + csvqs_pkg::LEN_W + csvqs_pkg::CNT_W
                               +: csvqs_pkg::CNT_W];
         got.last  = rsp_tlast;
         sb.check_event(got);
      end
   end

   // Pack up to eight characters, first character in lane 0.
   function automatic logic [63:0] text8(string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++)
         w[8*i +: 8] = s[i];
      return w;
   endfunction

   // Pick one byte of CSV-like text, biased toward the bytes that steer the scanner.
   function automatic logic [7:0] csv_byte(logic [7:0] delim);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12)
         return csvqs_pkg::QUOTE_BYTE;
      if (roll < 22)
         return csvqs_pkg::NEWLINE_BYTE;
      if (roll < 36)
         return delim;
      if (roll < 42)
         return csvqs_pkg::DELIM_RESET;
      if (roll < 47)
         return 8'($urandom);
      return 8'h61 + 8'($urandom_range(25));
   endfunction

   // Offer one beat, idling at random first; return at the edge that takes it.
   task automatic send_beat(input logic [63:0] lanes, input logic [3:0] vb, input logic rs);
      while (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(csvqs_pkg::REQ_TDATA_W - 68){1'b0}}, vb, lanes};
      req_tuser  <= rs;
      do @(posedge clock); while (!req_tready);
      sb.note_beat(lanes, vb, rs);
      beats_sent++;
   endtask

   task automatic random_beat();
      logic [63:0] lanes;
      logic [3:0]  vb;
      logic        rs;
      lanes = '0;
      // Mostly CSV-like text; some beats are raw noise to toggle every data bit.
      if ($urandom_range(99) < 10)
         lanes = {32'($urandom), 32'($urandom)};
      else
         for (int k = 0; k < 8; k++)
            lanes[8*k +: 8] = csv_byte(sb.delim);
      vb = ($urandom_range(99) < 70) ? 4'd8 : 4'($urandom_range(15));
      rs = ($urandom_range(99) < 10);
      send_beat(lanes, vb, rs);
   endtask

   // Drop valid, hold until every expected event is out, then let beats that carried
   // no structural byte clear the pipeline.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Two-phase register write; only called after settle().
   task automatic csr_write(input logic [csvqs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic reconfigure(input logic mode, input logic [7:0] delim);
      settle();
      csr_write(csvqs_pkg::REG_CELL_MODE, {31'b0, mode});
      csr_write(csvqs_pkg::REG_DELIMITER, {24'b0, delim});
      settings++;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: row mode, so commas pass as plain text.
      send_beat(text8("ab,c\nde\n"), 4'd8, 1'b1);
      send_beat(64'h0, 4'd8, 1'b0);
      send_beat({64{1'b1}}, 4'd8, 1'b0);

      // Cell mode with the default comma.
      reconfigure(1'b1, csvqs_pkg::DELIM_RESET);
      send_beat(text8("a,b,c\nd,"), 4'd8, 1'b0);
      send_beat(text8("\"x,y\n\","), 4'd8, 1'b0);     // structural bytes inside quotes
      send_beat(text8(",,,,,,,,"), 4'd8, 1'b0);       // a full burst of cell ends
      send_beat(text8("\n\n\n\n\n\n\n\n"), 4'd8, 1'b0);
      send_beat(text8("\n\n\n\n\n\n\n\n"), 4'd0, 1'b1); // no lanes, restart still clears
      send_beat(text8("abc\ndef,"), 4'd15, 1'b0);     // count above lane total
      send_beat(text8("q,r\ns,t,"), 4'd9, 1'b0);
      send_beat(text8("\nzzzzzzz"), 4'd1, 1'b0);
      send_beat(text8("abcdefgh"), 4'd8, 1'b0);
      send_beat(text8("ab,cd\n,e"), 4'd8, 1'b1);     // length restarts at lane 0
      send_beat(text8("ab\"cd,e\n"), 4'd8, 1'b0);     // quote left open across beats
      send_beat(text8("f\ng\"h,i\n"), 4'd8, 1'b1);

      // A quote used as the delimiter only toggles the flag.
      reconfigure(1'b1, csvqs_pkg::QUOTE_BYTE);
      send_beat(text8("a\"b,\"c\n\n"), 4'd8, 1'b0);

      // A newline used as the delimiter still ends rows.
      reconfigure(1'b1, csvqs_pkg::NEWLINE_BYTE);
      send_beat(text8("a\nb\"\n\"\n"), 4'd8, 1'b0);

      // Byte extremes as the delimiter.
      reconfigure(1'b1, 8'h00);
      send_beat(64'h0, 4'd8, 1'b0);
      reconfigure(1'b1, 8'hFF);
      send_beat({64{1'b1}}, 4'd8, 1'b1);

      // Random phases, one per register setting.
      for (int p = 0; p < PHASES; p++) begin
         reconfigure(phase_mode[p], phase_delim[p]);
         steady = (p == 2);
         for (int i = 0; i < 35; i++) begin
            // Halfway through one phase, hold until the event side has drained.
            if (p == 1 && i == 17)
               settle();
            random_beat();
         end
         steady = 1'b0;
      end

      settle();
      $display("Sent %0d beats over %0d register settings, checked %0d events", beats_sent,
               settings, sb.checked);
      $display("Covered quoted structural bytes, restarts, lane counts 0..15 and event bursts");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
rtl/csvqs_pkg.sv
rtl/csvqs_lane.sv
rtl/csvqs_merge.sv
rtl/csvqs_evq.sv
rtl/csv_quote_aware_delimiter_scanner.sv
dv/tb_top.sv
